>>> rtl/core/sdtq_pkg.sv
package sdtq_pkg;

	// Sizing of the queue. CAPACITY sets the depth of the entry store.
	localparam int CAPACITY  = 16;
	localparam int TIME_BITS = 32;
	localparam int NUM_IDS   = 16;

	localparam int ID_W  = 4;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Command codes.
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_ADJUST = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EXPIRED = 3'd1;
	localparam logic [2:0] ST_NONE    = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_DUP     = 3'd5;

	// One queue entry: timer id and its deadline.
	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [TIME_BITS-1:0] dl;
	} entry_t;

	// Access request from the sequencer to the entry store.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} store_req_t;

endpackage

>>> rtl/core/sorted_deadline_timer_queue_unit.sv
// Sorted deadline timer queue. The unit holds up to CAPACITY timers, each named
// by a 4-bit id, in ascending order of deadline in a single-port-read entry
// store, and takes one command word at a time: add, adjust, delete or tick.
// The input is stalled from the cycle after a word is accepted until its last
// result word has been loaded into the output register, so the unit takes no
// new word while a command is in progress. An add walks from the tail toward
// the insertion point, a delete scans the whole list, an adjust is a delete
// followed by an add, and a tick takes each expired entry out at the head in
// turn. The cost of each command comes from the one read port of the entry
// store, whose registered read data feeds one shared deadline comparator each
// step, and from moving entries one position per step. Add, adjust and
// delete give one result word; a tick gives one word per expired entry, oldest
// first, with last set on the final one, or a single "none due" word.
module sorted_deadline_timer_queue_unit
	import sdtq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  timer_id,
	input  logic [31:0] deadline,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_id,
	output logic [2:0]  status,
	output logic        last
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_RD  = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_RM_RD   = 3'd3;
	localparam logic [2:0] S_RM_CHK  = 3'd4;
	localparam logic [2:0] S_TK_RD   = 3'd5;
	localparam logic [2:0] S_TK_CMP  = 3'd6;
	localparam logic [2:0] S_FIN     = 3'd7;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     count_q;
	logic [NUM_IDS-1:0]   in_use_q;

	// Working registers of the current command.
	logic [1:0]           cmd_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     ptr_q;
	logic                 found_q;
	logic                 pend_v_q;
	logic [ID_W-1:0]      pend_id_q;
	logic [ID_W-1:0]      res_id_q;
	logic [2:0]           res_st_q;

	// Output register.
	logic                 out_valid_q;
	logic [ID_W-1:0]      out_id_q;
	logic [2:0]           status_q;
	logic                 last_q;

	store_req_t           req;
	entry_t               rd_data;
	entry_t               new_entry;
	logic [CNT_W-1:0]     ptr_m1;
	logic [TIME_BITS-1:0] cmp_b;
	logic                 gt;
	logic                 out_free;
	logic                 accept;
	logic                 emit;
	logic [ID_W-1:0]      emit_id;
	logic [2:0]           emit_st;
	logic                 emit_last;

	sdtq_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign ptr_m1    = ptr_q - 1'b1;
	assign new_entry = '{id: id_q, dl: dl_q};

	// The shared comparator: the stored deadline against the new deadline
	// during an insert, or against the current time during a tick.
	assign cmp_b = (cmd_q == CMD_TICK) ? now_q : dl_q;
	assign gt    = (rd_data.dl > cmp_b);

	always_comb begin
		req       = '0;
		emit      = 1'b0;
		emit_id   = res_id_q;
		emit_st   = res_st_q;
		emit_last = 1'b1;
		case (state_q)
			S_INS_RD: begin
				if (ptr_q == '0) begin
					req.wr_en   = 1'b1;
					req.wr_addr = '0;
					req.wr_data = new_entry;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = ptr_m1[IDX_W-1:0];
				end
			end
			S_INS_CMP: begin
				// A later deadline moves up one place; otherwise the new
				// entry lands here, behind any equal deadlines.
				req.wr_en   = 1'b1;
				req.wr_addr = ptr_q[IDX_W-1:0];
				req.wr_data = gt ? rd_data : new_entry;
			end
			S_RM_RD: begin
				if (ptr_q != count_q) begin
					req.rd_en   = 1'b1;
					req.rd_addr = ptr_q[IDX_W-1:0];
				end
			end
			S_RM_CHK: begin
				if (found_q) begin
					req.wr_en   = 1'b1;
					req.wr_addr = ptr_m1[IDX_W-1:0];
					req.wr_data = rd_data;
				end
			end
			S_TK_RD: begin
				if (count_q != '0) begin
					req.rd_en   = 1'b1;
					req.rd_addr = '0;
				end
			end
			S_TK_CMP: begin
				// A further due entry means the held one is not the last.
				if (!gt && pend_v_q && out_free) begin
					emit      = 1'b1;
					emit_id   = pend_id_q;
					emit_st   = ST_EXPIRED;
					emit_last = 1'b0;
				end
			end
			S_FIN: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			in_use_q <= '0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd;
						id_q     <= timer_id;
						dl_q     <= deadline[TIME_BITS-1:0];
						now_q    <= now[TIME_BITS-1:0];
						res_id_q <= timer_id;
						ptr_q    <= (cmd == CMD_ADD) ? count_q : '0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						case (cmd)
							CMD_ADD: begin
								if (in_use_q[timer_id]) begin
									res_st_q <= ST_DUP;
									state_q  <= S_FIN;
								end else if (count_q >= CNT_W'(CAPACITY)) begin
									res_st_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_INS_RD;
								end
							end
							CMD_ADJUST, CMD_DELETE: begin
								if (!in_use_q[timer_id]) begin
									res_st_q <= ST_UNKNOWN;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_RM_RD;
								end
							end
							default: begin
								state_q <= S_TK_RD;
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (ptr_q == '0) begin
						count_q        <= count_q + 1'b1;
						in_use_q[id_q] <= 1'b1;
						res_st_q       <= ST_OK;
						state_q        <= S_FIN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (gt) begin
						ptr_q   <= ptr_m1;
						state_q <= S_INS_RD;
					end else begin
						count_q        <= count_q + 1'b1;
						in_use_q[id_q] <= 1'b1;
						res_st_q       <= ST_OK;
						state_q        <= S_FIN;
					end
				end
				S_RM_RD: begin
					if (ptr_q == count_q) begin
						count_q <= count_q - 1'b1;
						if (cmd_q == CMD_ADJUST) begin
							// Re-insert with the new deadline into the
							// shortened list.
							ptr_q   <= count_q - 1'b1;
							state_q <= S_INS_RD;
						end else if (cmd_q == CMD_TICK) begin
							in_use_q[id_q] <= 1'b0;
							state_q        <= S_TK_RD;
						end else begin
							in_use_q[id_q] <= 1'b0;
							res_st_q       <= ST_OK;
							state_q        <= S_FIN;
						end
					end else begin
						state_q <= S_RM_CHK;
					end
				end
				S_RM_CHK: begin
					found_q <= found_q || (rd_data.id == id_q);
					ptr_q   <= ptr_q + 1'b1;
					state_q <= S_RM_RD;
				end
				S_TK_RD: begin
					if (count_q == '0) begin
						res_id_q <= pend_v_q ? pend_id_q : '0;
						res_st_q <= pend_v_q ? ST_EXPIRED : ST_NONE;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_TK_CMP;
					end
				end
				S_TK_CMP: begin
					if (gt) begin
						res_id_q <= pend_v_q ? pend_id_q : '0;
						res_st_q <= pend_v_q ? ST_EXPIRED : ST_NONE;
						state_q  <= S_FIN;
					end else if (!pend_v_q || out_free) begin
						// Hold the head as the pending result and take it out
						// of the list; its slot is found at once.
						pend_id_q <= rd_data.id;
						pend_v_q  <= 1'b1;
						id_q      <= rd_data.id;
						ptr_q     <= '0;
						found_q   <= 1'b0;
						state_q   <= S_RM_RD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register; the sequencer loads it only when it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_id_q <= emit_id;
			status_q <= emit_st;
			last_q   <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_id    = out_id_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

>>> rtl/core/sdtq_store.sv
module sdtq_store
	import sdtq_pkg::*;
(
	input  logic       clk,
	input  store_req_t req,
	output entry_t     rd_data
);

	// Entries in deadline order, one write and one registered read per cycle.
	entry_t mem [CAPACITY];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/core/sdtq_checker.sv
module sdtq_checker
	import sdtq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  out_id,
	input logic [2:0]  status,
	input logic        last
);

	// The unit works on one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_id)
			&& $stable(status) && $stable(last)))
		else $error("stalled result word changed");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_EXPIRED) |-> last)
		else $error("single-word result without last");

	a_none_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NONE) |-> (out_id == '0))
		else $error("none-due result with nonzero id");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_DUP))
		else $error("undefined status code");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_id    (out_id),
	.status    (status),
	.last      (last)
);

>>> sim/sorted_deadline_timer_queue_unit_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the timer queue, keeps a shadow of the sorted
// store and compares every result word with the oldest predicted one.
module sorted_deadline_timer_queue_unit_checker
	import sdtq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic [1:0]      cmd,
	input  logic [ID_W-1:0] timer_id,
	input  logic [31:0]     deadline,
	input  logic [31:0]     now,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic [ID_W-1:0] out_id,
	input  logic [2:0]      status,
	input  logic            last,
	output int              mismatches,
	output int              outstanding
);

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [2:0]      status;
		logic            last;
	} timer_reply_t;

	// Shadow of the queue: ids and deadlines in deadline order.
	logic [ID_W-1:0]      sorted_ids [CAPACITY];
	logic [TIME_BITS-1:0] sorted_dls [CAPACITY];
	int                   live_count;
	logic [NUM_IDS-1:0]   id_live;

	timer_reply_t expected_replies [$];
	int           replies_seen;

	initial mismatches = 0;

	task automatic flag_mismatch(input string what);
		$display("%0t ns: result word %0d: %s", $time, replies_seen, what);
		mismatches++;
	endtask

	task automatic push_reply(input logic [ID_W-1:0] id, input logic [2:0] st,
			input logic fin);
		timer_reply_t r;
		r.id = id;
		r.status = st;
		r.last = fin;
		expected_replies.push_back(r);
	endtask

	// An equal deadline lands after the entries already carrying it.
	task automatic insert_entry(input logic [ID_W-1:0] id, input logic [TIME_BITS-1:0] dl);
		int pos;
		pos = 0;
		while (pos < live_count && sorted_dls[pos] <= dl)
			pos++;
		for (int i = live_count; i > pos; i--) begin
			sorted_ids[i] = sorted_ids[i-1];
			sorted_dls[i] = sorted_dls[i-1];
		end
		sorted_ids[pos] = id;
		sorted_dls[pos] = dl;
		live_count++;
		id_live[id] = 1'b1;
	endtask

	task automatic remove_entry(input int pos);
		id_live[sorted_ids[pos]] = 1'b0;
		for (int i = pos; i + 1 < live_count; i++) begin
			sorted_ids[i] = sorted_ids[i+1];
			sorted_dls[i] = sorted_dls[i+1];
		end
		live_count--;
	endtask

	task automatic predict_command(input logic [1:0] op, input logic [ID_W-1:0] id,
			input logic [31:0] dl_word, input logic [31:0] now_word);
		logic [TIME_BITS-1:0] dl;
		logic [TIME_BITS-1:0] t;
		logic [ID_W-1:0]      gone [NUM_IDS];
		int                   pos;
		int                   n;
		dl = TIME_BITS'(dl_word);
		t = TIME_BITS'(now_word);
		case (op)
		CMD_ADD: begin
			if (id_live[id])
				push_reply(id, ST_DUP, 1'b1);
			else if (live_count >= CAPACITY)
				push_reply(id, ST_FULL, 1'b1);
			else begin
				insert_entry(id, dl);
				push_reply(id, ST_OK, 1'b1);
			end
		end
		CMD_ADJUST, CMD_DELETE: begin
			pos = -1;
			if (id_live[id]) begin
				for (int i = 0; i < live_count; i++)
					if (pos < 0 && sorted_ids[i] == id)
						pos = i;
			end
			if (pos < 0)
				push_reply(id, ST_UNKNOWN, 1'b1);
			else begin
				remove_entry(pos);
				if (op == CMD_ADJUST)
					insert_entry(id, dl);
				push_reply(id, ST_OK, 1'b1);
			end
		end
		CMD_TICK: begin
			n = 0;
			while (live_count > 0 && sorted_dls[0] <= t && n < NUM_IDS) begin
				gone[n] = sorted_ids[0];
				remove_entry(0);
				n++;
			end
			if (n == 0)
				push_reply('0, ST_NONE, 1'b1);
			for (int k = 0; k < n; k++)
				push_reply(gone[k], ST_EXPIRED, k == n - 1);
		end
		endcase
	endtask

	task automatic check_reply();
		timer_reply_t want;
		if (expected_replies.size() == 0) begin
			flag_mismatch($sformatf("unexpected word id=%0d status=%0d last=%0b",
				out_id, status, last));
		end else begin
			want = expected_replies.pop_front();
			if (out_id !== want.id)
				flag_mismatch($sformatf("out_id %0d, expected %0d", out_id, want.id));
			if (status !== want.status)
				flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
			if (last !== want.last)
				flag_mismatch($sformatf("last %0b, expected %0b", last, want.last));
		end
		replies_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count = 0;
			id_live = '0;
			replies_seen = 0;
			expected_replies.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_command(cmd, timer_id, deadline, now);
			if (out_valid && !out_stall)
				check_reply();
			outstanding <= expected_replies.size();
		end
	end

endmodule

>>> sim/sorted_deadline_timer_queue_unit_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the sorted deadline timer queue. The checker beside
// the block does all prediction and comparison; this module only drives command
// words, stalls the result channel and decides pass or fail at the end.
module sorted_deadline_timer_queue_unit_tb;
	import sdtq_pkg::*;

	// A tick that expires a full store is the slowest word, before the receiver's
	// stalls are added; the limit leaves a wide margin above a run in which every
	// word were that slow.
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_WORDS = 260;
	localparam int DRAIN_CYCLES = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_TICK;
	logic [3:0]  timer_id = '0;
	logic [31:0] deadline = '0;
	logic [31:0] now = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  out_id;
	logic [2:0]  status;
	logic        last;

	int mismatches;
	int outstanding;
	int cycle_count = 0;

	// Bookkeeping for the stimulus only: which ids are queued and with which
	// deadline, so that most random words act on timers that really exist.
	logic [15:0] armed = '0;
	logic [31:0] armed_dl [16];

	// Random deadlines cluster around a moving point in time. The epoch jumps
	// now and then (including right below the wrap point), and the cursor
	// creeps forward with each tick so that entries expire a few at a time.
	logic [31:0] epoch = '0;
	logic [31:0] cursor = '0;

	always #4 clk = ~clk;

	sorted_deadline_timer_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.timer_id  (timer_id),
		.deadline  (deadline),
		.now       (now),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_id    (out_id),
		.status    (status),
		.last      (last)
	);

	sorted_deadline_timer_queue_unit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.timer_id    (timer_id),
		.deadline    (deadline),
		.now         (now),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_id      (out_id),
		.status      (status),
		.last        (last),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog: a hung handshake or a lost result word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** sorted_deadline_timer_queue_unit: FAILED **");
			$finish;
		end
	end

	// The receiver switches between three stall styles: never stalling,
	// stalling at random about a third of the time, or a fixed on/off pattern.
	// The periods are chosen so that stalls land on every phase of a command.
	int rx_cycle = 0;
	int rx_mode = 0;
	int rx_period = 5;
	always @(negedge clk) begin
		if (rx_cycle % 128 == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_period = $urandom_range(3, 9);
		end
		rx_cycle++;
		case (rx_mode)
		0: out_stall <= 1'b0;
		1: out_stall <= ($urandom_range(0, 99) < 33);
		default: out_stall <= ((rx_cycle % rx_period) < 2);
		endcase
	end

	// Presents one command word from a falling edge and holds it until the
	// block takes it. The stall is looked at on falling edges, where it is
	// settled and equals what the next rising edge sees. Returns on the
	// falling edge after the accepting edge with valid still high, so that
	// back-to-back words keep valid asserted.
	task automatic send_word(input logic [1:0] op, input logic [3:0] id,
			input logic [31:0] dl, input logic [31:0] t);
		in_valid <= 1'b1;
		cmd <= op;
		timer_id <= id;
		deadline <= dl;
		now <= t;
		case (op)
		CMD_ADD: if (!armed[id]) begin
			armed[id] = 1'b1;
			armed_dl[id] = dl;
		end
		CMD_ADJUST: if (armed[id]) armed_dl[id] = dl;
		CMD_DELETE: armed[id] = 1'b0;
		CMD_TICK: for (int k = 0; k < 16; k++)
			if (armed[k] && armed_dl[k] <= t)
				armed[k] = 1'b0;
		endcase
		while (in_stall)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Only called with at least one cycle, so valid never drops and rises
	// again within the same time step.
	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Picks an id that is queued (want_armed) or free, starting at a random
	// point; falls back to a random id when none matches.
	function automatic logic [3:0] pick_id(input bit want_armed);
		logic [3:0] start;
		start = 4'($urandom_range(0, 15));
		for (int k = 0; k < 16; k++)
			if (armed[4'(start + k)] == want_armed)
				return 4'(start + k);
		return start;
	endfunction

	// Mostly near the cursor, sometimes an exact copy of a queued deadline to
	// force ties, and sometimes anywhere in the 32-bit range.
	function automatic logic [31:0] next_deadline();
		int         r;
		logic [3:0] mate;
		r = $urandom_range(0, 99);
		mate = pick_id(1'b1);
		if (r < 15 && armed[mate])
			return armed_dl[mate];
		if (r < 25)
			return $urandom();
		return epoch + cursor + $urandom_range(0, 40);
	endfunction

	initial begin
		int pick;
		int burst_left;
		int gap;
		logic [31:0] t;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. A tick on the empty store, then adjust and delete of
		// ids that were never added.
		send_word(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_word(CMD_DELETE, 4'd5, 32'd0, 32'd0);
		send_word(CMD_ADJUST, 4'd9, 32'd77, 32'd0);

		// Fill the store with every id: the latest possible deadline, the
		// earliest, a run of four equal deadlines and a descending tail.
		send_word(CMD_ADD, 4'd0, 32'hFFFF_FFFF, 32'd0);
		send_word(CMD_ADD, 4'd15, 32'd0, 32'hFFFF_FFFF);
		for (int i = 1; i <= 4; i++)
			send_word(CMD_ADD, 4'(i), 32'd100, 32'd0);
		for (int i = 5; i <= 14; i++)
			send_word(CMD_ADD, 4'(i), 32'((20 - i) * 1000), 32'd0);

		// With CAPACITY equal to the number of ids, a full store means every
		// id is queued, so the duplicate check always wins and a full status
		// cannot be provoked. This add hits both conditions at once.
		send_word(CMD_ADD, 4'd7, 32'd5, 32'd0);

		// Re-sorting onto an equal deadline moves the entry behind its peers.
		send_word(CMD_ADJUST, 4'd2, 32'd100, 32'd0);
		send_word(CMD_DELETE, 4'd15, 32'd0, 32'd0);
		send_word(CMD_TICK, 4'd0, 32'd0, 32'd99);
		// Everything left expires in one tick: the longest result burst.
		send_word(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);

		// Random part: bursts of words separated by random gaps, with every
		// third stretch of 64 words sent without any gap at all.
		burst_left = 0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 0) begin
				pick = $urandom_range(0, 3);
				epoch = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFE0 : $urandom();
				cursor = '0;
				if ($urandom_range(0, 1))
					send_word(CMD_TICK, 4'($urandom()), $urandom(), 32'hFFFF_FFFF);
			end
			if (burst_left == 0) begin
				gap = ((n / 64) % 3 == 0) ? 0 : $urandom_range(0, 6);
				if (gap > 0)
					pause_sender(gap);
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;

			// Mostly commands that act on real timers; about one in ten adds
			// targets a queued id and one in ten adjusts or deletes a free one.
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_word(CMD_ADD, pick_id($urandom_range(0, 9) == 0), next_deadline(),
					$urandom());
			end else if (pick < 55) begin
				send_word(CMD_ADJUST, pick_id($urandom_range(0, 9) != 0), next_deadline(),
					$urandom());
			end else if (pick < 65) begin
				send_word(CMD_DELETE, pick_id($urandom_range(0, 9) != 0), $urandom(),
					$urandom());
			end else begin
				cursor = cursor + $urandom_range(0, 12);
				t = ($urandom_range(0, 6) == 0) ? $urandom() : epoch + cursor;
				send_word(CMD_TICK, 4'($urandom()), $urandom(), t);
			end
		end
		pause_sender(1);

		// Wait for the last result words, then give the block time to show
		// any stray word it should not produce.
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("** sorted_deadline_timer_queue_unit: PASSED **");
		end else begin
			$display("** sorted_deadline_timer_queue_unit: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/sdtq_pkg.sv
rtl/core/sdtq_store.sv
rtl/core/sorted_deadline_timer_queue_unit.sv
rtl/core/sdtq_checker.sv
sim/sorted_deadline_timer_queue_unit_checker.sv
sim/sorted_deadline_timer_queue_unit_tb.sv
